### hw/rtl/dfa_table_byte_matcher_core_assert.svh
// assertion macros for the dfa byte matcher checker
// no dependencies; taken in by include where assertions are written
`ifndef DFA_TABLE_BYTE_MATCHER_CORE_ASSERT_SVH
`define DFA_TABLE_BYTE_MATCHER_CORE_ASSERT_SVH

// plain clocked assertion, checked on every edge
`define DFATM_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// clocked assertion, switched off while the reset is asserted
`define DFATM_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

### hw/rtl/dfatm_pkg.sv
// shared types and constants of the dfa table byte matcher
// used by the top level and the checker; no dependencies
`default_nettype none

package dfatm_pkg;

    localparam int DEF_TABLE_ROWS = 1024;
    localparam int ALPHABET       = 256;
    localparam int SYM_W          = 8;
    localparam int STATE_W        = 10;
    localparam int KIND_W         = 2;
    localparam int ENTRY_W        = KIND_W + STATE_W;
    localparam int POS_W          = 16;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;

    typedef enum logic [1:0] {
        CMD_WRITE_ENTRY = 2'd0,
        CMD_WRITE_MATCH = 2'd1,
        CMD_SCAN        = 2'd2
    } cmd_t;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_NORMAL = 2'd0;
    localparam kind_t KIND_DEAD   = 2'd1;
    localparam kind_t KIND_ACCEPT = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/dfatm_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module dfatm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/dfa_table_byte_matcher_core.sv
// top level of the table driven dfa byte matcher
// depends on dfatm_pkg and dfatm_ram
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready, tlast      tdata: entry fields, tuser: command, first byte
//  m_axis    out  tvalid/tready             tdata: matched, stop position
//
// table and match writes do not hold off the next beat. after a scan byte the input is held
// off while the registered transition ram read completes, since the next byte's row comes from it.
// a byte of an already decided buffer does not hold off the next beat.
// after reset a clearing pass over all TABLE_ROWS rows zeroes the match flags; no beat is
// taken meanwhile. a result waiting in the output register holds off every input beat.
`default_nettype none

module dfa_table_byte_matcher_core
    import dfatm_pkg::*;
#(
    parameter int TABLE_ROWS = DEF_TABLE_ROWS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // table_row, symbol, entry_kind, entry_state, match_bit, dfa_base, zero fill
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // command, first_byte
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
    input  wire logic                 s_axis_tlast,

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // matched, stop_position, zero fill
    output logic      [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int ROW_W  = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int ADDR_W = ROW_W + SYM_W;
    localparam int DEPTH  = TABLE_ROWS * ALPHABET;
    localparam int WIDE_W = ((ROW_W > STATE_W) ? ROW_W : STATE_W) + 1;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TABLE_ROWS - 1);

    // relative state reduced modulo the row count by conditional subtraction
    function automatic logic [STATE_W-1:0] reduce_rel(input logic [STATE_W-1:0] v);
        logic [STATE_W-1:0] r;
        r = v;
        for (int k = STATE_W; k >= 0; k--) begin
            if ((TABLE_ROWS << k) < (1 << STATE_W) && int'(r) >= (TABLE_ROWS << k)) begin
                r = r - STATE_W'(TABLE_ROWS << k);
            end
        end
        return r;
    endfunction

    // both operands already below the row count
    function automatic logic [ROW_W-1:0] row_add(input logic [ROW_W-1:0] base,
                                                 input logic [STATE_W-1:0] rel);
        logic [WIDE_W-1:0] sum;
        sum = WIDE_W'(base) + WIDE_W'(rel);
        if (sum >= WIDE_W'(TABLE_ROWS)) begin
            sum = sum - WIDE_W'(TABLE_ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    // input fields
    logic [9:0]         in_table_row;
    logic [SYM_W-1:0]   in_symbol;
    kind_t              in_entry_kind;
    logic [STATE_W-1:0] in_entry_state;
    logic               in_match_bit;
    logic [9:0]         in_dfa_base;
    cmd_t               in_command;
    logic               in_first;
    logic               in_last;

    assign in_table_row   = s_axis_tdata[9:0];
    assign in_symbol      = s_axis_tdata[17:10];
    assign in_entry_kind  = s_axis_tdata[19:18];
    assign in_entry_state = s_axis_tdata[29:20];
    assign in_match_bit   = s_axis_tdata[30];
    assign in_dfa_base    = s_axis_tdata[40:31];
    assign in_command     = cmd_t'(s_axis_tuser[1:0]);
    assign in_first       = s_axis_tuser[2];
    assign in_last        = s_axis_tlast;

    // control state
    logic               clear_reg, clear_next;
    logic [ROW_W-1:0]   clear_cnt_reg, clear_cnt_next;
    logic               busy_reg, busy_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [ROW_W-1:0]   base_reg, base_next;
    kind_t              kind_reg, kind_next;
    logic               decided_reg, decided_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               m_valid_reg, m_valid_next;

    // payload
    logic               b_last_reg, b_last_next;
    kind_t              b_kind_reg, b_kind_next;
    logic [POS_W-1:0]   b_pos_reg, b_pos_next;
    logic               m_matched_reg, m_matched_next;
    logic [POS_W-1:0]   m_pos_reg, m_pos_next;

    // ram ports
    logic               st_we;
    logic [ADDR_W-1:0]  st_waddr;
    logic [ENTRY_W-1:0] st_wdata;
    logic [ADDR_W-1:0]  st_raddr;
    logic [ENTRY_W-1:0] st_rdata;
    logic               mf_we;
    logic [ROW_W-1:0]   mf_waddr;
    logic               mf_wdata;
    logic [ROW_W-1:0]   mf_raddr;
    logic               mf_rdata;

    logic               accept;
    logic               row_ok;
    logic [ROW_W-1:0]   base_in;
    logic [ROW_W-1:0]   eff_row;
    logic [ROW_W-1:0]   eff_base;
    kind_t              eff_kind;
    logic               eff_decided;
    logic [POS_W-1:0]   eff_pos;
    logic               scan_go;
    kind_t              rd_kind;
    logic [STATE_W-1:0] rd_state;

    assign s_axis_tready = !clear_reg && !busy_reg && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign row_ok        = int'(in_table_row) < TABLE_ROWS;
    assign base_in       = ROW_W'(reduce_rel(in_dfa_base));

    // a first byte restarts the buffer before the byte is looked at
    assign eff_row     = in_first ? base_in : row_reg;
    assign eff_base    = in_first ? base_in : base_reg;
    assign eff_kind    = in_first ? KIND_NORMAL : kind_reg;
    assign eff_decided = in_first ? 1'b0 : decided_reg;
    assign eff_pos     = in_first ? '0 : pos_reg;
    assign scan_go     = accept && (in_command == CMD_SCAN) && !eff_decided;

    assign st_we    = accept && (in_command == CMD_WRITE_ENTRY) && row_ok;
    assign st_waddr = {ROW_W'(in_table_row), in_symbol};
    assign st_wdata = (in_entry_kind == KIND_NORMAL) ?
                      {in_entry_kind, reduce_rel(in_entry_state)} :
                      {in_entry_kind, {STATE_W{1'b0}}};
    assign st_raddr = {eff_row, in_symbol};

    assign mf_we    = clear_reg || (accept && (in_command == CMD_WRITE_MATCH) && row_ok);
    assign mf_waddr = clear_reg ? clear_cnt_reg : ROW_W'(in_table_row);
    assign mf_wdata = clear_reg ? 1'b0 : in_match_bit;
    assign mf_raddr = eff_row;

    assign rd_kind  = st_rdata[ENTRY_W-1:STATE_W];
    assign rd_state = st_rdata[STATE_W-1:0];

    dfatm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_trans_ram (
        .clk   (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    dfatm_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_ROWS)
    ) u_match_ram (
        .clk   (aclk),
        .we    (mf_we),
        .waddr (mf_waddr),
        .wdata (mf_wdata),
        .raddr (mf_raddr),
        .rdata (mf_rdata)
    );

    always_comb begin
        clear_next     = clear_reg;
        clear_cnt_next = clear_cnt_reg;
        busy_next      = busy_reg;
        row_next       = row_reg;
        base_next      = base_reg;
        kind_next      = kind_reg;
        decided_next   = decided_reg;
        pos_next       = pos_reg;
        m_valid_next   = m_valid_reg;
        b_last_next    = b_last_reg;
        b_kind_next    = b_kind_reg;
        b_pos_next     = b_pos_reg;
        m_matched_next = m_matched_reg;
        m_pos_next     = m_pos_reg;

        if (clear_reg) begin
            clear_cnt_next = clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == LAST_ROW) begin
                clear_next = 1'b0;
            end
        end

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        if (accept && (in_command == CMD_SCAN) && in_first) begin
            row_next     = eff_row;
            base_next    = eff_base;
            kind_next    = KIND_NORMAL;
            decided_next = 1'b0;
            pos_next     = '0;
        end

        // lookup issued: reads are on their way, result comes next cycle
        if (scan_go) begin
            pos_next    = (eff_pos == POS_MAX) ? eff_pos : eff_pos + 1'b1;
            busy_next   = 1'b1;
            b_last_next = in_last;
            b_kind_next = eff_kind;
            b_pos_next  = eff_pos;
        end

        if (busy_reg) begin
            busy_next  = 1'b0;
            m_pos_next = b_pos_reg;
            if (b_kind_reg == KIND_ACCEPT) begin
                m_valid_next   = 1'b1;
                m_matched_next = 1'b1;
                decided_next   = 1'b1;
            end else if (b_kind_reg != KIND_NORMAL) begin
                m_valid_next   = 1'b1;
                m_matched_next = 1'b0;
                decided_next   = 1'b1;
            end else if (mf_rdata) begin
                m_valid_next   = 1'b1;
                m_matched_next = 1'b1;
                decided_next   = 1'b1;
            end else begin
                kind_next = rd_kind;
                row_next  = row_add(base_reg, (rd_kind == KIND_NORMAL) ? rd_state : '0);
                if (b_last_reg) begin
                    m_valid_next   = 1'b1;
                    m_matched_next = 1'b0;
                    decided_next   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
            busy_reg      <= 1'b0;
            row_reg       <= '0;
            base_reg      <= '0;
            kind_reg      <= KIND_NORMAL;
            decided_reg   <= 1'b0;
            pos_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            clear_reg     <= clear_next;
            clear_cnt_reg <= clear_cnt_next;
            busy_reg      <= busy_next;
            row_reg       <= row_next;
            base_reg      <= base_next;
            kind_reg      <= kind_next;
            decided_reg   <= decided_next;
            pos_reg       <= pos_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_last_reg    <= b_last_next;
        b_kind_reg    <= b_kind_next;
        b_pos_reg     <= b_pos_next;
        m_matched_reg <= m_matched_next;
        m_pos_reg     <= m_pos_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - POS_W - 1){1'b0}}, m_pos_reg, m_matched_reg};

endmodule

`default_nettype wire

### hw/rtl/dfatm_checker.sv
// port level checker of the dfa table byte matcher, bound to the top level
// depends on dfatm_pkg and dfa_table_byte_matcher_core_assert.svh
`default_nettype none

`include "dfa_table_byte_matcher_core_assert.svh"

module dfatm_checker
    import dfatm_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input wire logic [S_TUSER_W-1:0] s_axis_tuser,
    input wire logic                 s_axis_tlast,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic scan_beat;

    assign scan_beat = s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == CMD_SCAN);

    // the match flags are being cleared right after reset
    `DFATM_ASSERT(a_no_beat_after_reset, aclk, !aresetn |=> !s_axis_tready, "beat taken during clear")

    // every new result comes from an earlier scan beat, through the busy and output registers
    `DFATM_ASSERT_RST(a_result_from_scan, aclk, aresetn, $rose(m_axis_tvalid) |-> $past(scan_beat, 2), "result without scan beat")

    // a waiting result holds until taken
    `DFATM_ASSERT_RST(a_result_held, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed")

    // padding bits of the result stay zero
    `DFATM_ASSERT_RST(a_result_pad, aclk, aresetn, m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:POS_W+1] == '0), "result padding not zero")

endmodule

bind dfa_table_byte_matcher_core dfatm_checker u_dfatm_checker (.*);

`default_nettype wire
